FILE: hdl/lsbsd_pkg.sv
// ----------------------------------------------------------------------------
// lsbsd_pkg
// Shared types and constants of the bmp lsb deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbsd_pkg;

  parameter int ByteW      = 8;
  parameter int MagicW     = 16;
  parameter int HdrLenW    = 8;
  parameter int LenW       = 32;
  parameter int BitCntW    = 5;
  parameter int CfgIdxW    = 1;
  parameter int CfgDataW   = 16;
  parameter int QueueDepth = 2;

  parameter logic [MagicW-1:0]  MagicReset  = 16'd10787;
  parameter logic [HdrLenW-1:0] HeaderReset = 8'd54;

  // last bit position of each field in the hidden stream
  parameter logic [BitCntW-1:0] LastMagicBit = 5'd15;
  parameter logic [BitCntW-1:0] LastLenBit   = 5'd31;
  parameter logic [BitCntW-1:0] LastUnitBit  = 5'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC  = 1'b0,
    CFG_HEADER = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_EXT = 2'd0,
    KIND_PAY = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  // one hidden bit handed from the front to the back
  typedef struct packed {
    logic hid_bit;
    logic restart;
  } fwd_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_t            kind;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/lsbsd_ifs.sv
// ----------------------------------------------------------------------------
// lsbsd channel interfaces
// Valid/ready channels for file bytes, decoded results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsbsd_in_if
  import lsbsd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] file_byte;
  logic             start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface lsbsd_out_if
  import lsbsd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [1:0]       kind;
  logic             last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

interface lsbsd_cfg_if
  import lsbsd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/lsbsd_front.sv
// ----------------------------------------------------------------------------
// lsbsd_front
// Skips the file header and forwards the lsb of each later byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbsd_front
  import lsbsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [ByteW-1:0]   file_byte,
  input  wire logic               start_of_file,
  input  wire logic [HdrLenW-1:0] header_length,
  output      logic               push,
  output      fwd_t               push_item
);

  logic               in_hdr_r,  in_hdr_nxt;
  logic [HdrLenW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic               hdr_now;
  logic [HdrLenW-1:0] hdr_cnt_now;

  always_comb begin
    hdr_now     = start_of_file ? 1'b1 : in_hdr_r;
    hdr_cnt_now = start_of_file ? '0 : hdr_cnt_r;
    in_hdr_nxt  = in_hdr_r;
    hdr_cnt_nxt = hdr_cnt_r;
    push        = 1'b0;
    push_item   = '{hid_bit: file_byte[0], restart: 1'b0};
    if (accept) begin
      if (hdr_now && (hdr_cnt_now < header_length)) begin
        in_hdr_nxt  = 1'b1;
        hdr_cnt_nxt = hdr_cnt_now + 1'b1;
      end else begin
        // first hidden bit after a header restarts the back end
        push              = 1'b1;
        push_item.restart = hdr_now;
        in_hdr_nxt        = 1'b0;
        hdr_cnt_nxt       = hdr_cnt_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hdr_r  <= 1'b1;
      hdr_cnt_r <= '0;
    end else begin
      in_hdr_r  <= in_hdr_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lsbsd_queue.sv
// ----------------------------------------------------------------------------
// lsbsd_queue
// Short fifo of hidden bits between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbsd_queue
  import lsbsd_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire fwd_t push_item,
  input  wire logic pop,
  output      logic full,
  output      logic not_empty,
  output      fwd_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  fwd_t            slots_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: hdl/lsbsd_back.sv
// ----------------------------------------------------------------------------
// lsbsd_back
// Assembles hidden bits into magic, lengths, extension and payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbsd_back
  import lsbsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire fwd_t              q_item,
  output      logic              pop,
  input  wire logic [MagicW-1:0] magic_word,
  output      logic              res_valid,
  output      result_t           res,
  input  wire logic              res_ready
);

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_EXT_LEN,
    PH_EXT_CHARS,
    PH_PAY_LEN,
    PH_PAYLOAD,
    PH_DONE,
    PH_HALTED
  } phase_t;

  phase_t             phase_r,  phase_nxt;
  logic [BitCntW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [LenW-1:0]    shift_r,  shift_nxt;
  logic [LenW-1:0]    remain_r, remain_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r,    out_nxt;

  phase_t             ph;
  logic [BitCntW-1:0] cnt;
  logic               produce;
  result_t            new_res;
  logic [LenW-1:0]    remain_dec;

  assign pop       = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    ph          = q_item.restart ? PH_MAGIC : phase_r;
    cnt         = q_item.restart ? '0 : bit_cnt_r;
    // bits enter at the top, so a finished field sits in the upper bits
    shift_nxt   = {q_item.hid_bit, shift_r[LenW-1:1]};
    phase_nxt   = ph;
    bit_cnt_nxt = cnt + 1'b1;
    remain_nxt  = remain_r;
    remain_dec  = remain_r - 1'b1;
    produce     = 1'b0;
    new_res     = '{data: shift_nxt[LenW-1 -: ByteW], kind: KIND_EXT, last: 1'b0};
    unique case (ph)
      PH_MAGIC: begin
        if (cnt == LastMagicBit) begin
          bit_cnt_nxt = '0;
          if (shift_nxt[LenW-1 -: MagicW] != magic_word) begin
            phase_nxt    = PH_HALTED;
            produce      = 1'b1;
            new_res.data = '0;
            new_res.kind = KIND_ERR;
          end else begin
            phase_nxt = PH_EXT_LEN;
          end
        end
      end
      PH_EXT_LEN, PH_PAY_LEN: begin
        if (cnt == LastLenBit) begin
          bit_cnt_nxt = '0;
          remain_nxt  = shift_nxt;
          if (ph == PH_EXT_LEN) begin
            phase_nxt = (shift_nxt != '0) ? PH_EXT_CHARS : PH_PAY_LEN;
          end else begin
            phase_nxt = (shift_nxt != '0) ? PH_PAYLOAD : PH_DONE;
          end
        end
      end
      PH_EXT_CHARS, PH_PAYLOAD: begin
        if (cnt == LastUnitBit) begin
          bit_cnt_nxt = '0;
          remain_nxt  = remain_dec;
          produce     = 1'b1;
          if (ph == PH_PAYLOAD) begin
            new_res.kind = KIND_PAY;
          end
          if (remain_dec == '0) begin
            if (ph == PH_PAYLOAD) begin
              new_res.last = 1'b1;
              phase_nxt    = PH_DONE;
            end else begin
              phase_nxt = PH_PAY_LEN;
            end
          end
        end
      end
      default: begin
        // done or halted: bits are dropped until the next file
        bit_cnt_nxt = cnt;
        shift_nxt   = shift_r;
      end
    endcase

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_ready;
    if (pop && produce) begin
      out_valid_nxt = 1'b1;
      out_nxt       = new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (pop) begin
      shift_r  <= shift_nxt;
      remain_r <= remain_nxt;
    end
    out_r <= out_nxt;
  end

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_ERR) |-> (out_r.data == '0 && !out_r.last))
    else $error("error result carries data");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (out_r.kind == KIND_PAY))
    else $error("last flag on a non-payload result");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && produce && new_res.last) |=> (phase_r == PH_DONE))
    else $error("final payload byte did not end the file");

  a_halt_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && produce && new_res.kind == KIND_ERR) |=> (phase_r == PH_HALTED))
    else $error("magic mismatch did not halt decoding");

endmodule

`default_nettype wire

FILE: hdl/lsb_stego_bmp_deframer.sv
// ----------------------------------------------------------------------------
// lsb_stego_bmp_deframer
// Recovers the extension and payload hidden in the lsbs of a bmp file.
// ----------------------------------------------------------------------------
// in_chan takes one file byte per transfer; start_of_file on a byte restarts
// decoding with that byte as header byte zero. The first header_length bytes
// are skipped, then the lsb of each byte builds, lsb first: a 16-bit magic,
// a 32-bit extension length, the extension characters, a 32-bit payload
// length and the payload bytes. out_chan gives one transfer per extension
// character (kind 0) or payload byte (kind 1, last on the final one), or a
// single kind 2 transfer on a magic mismatch, after which bytes are dropped
// until the next start of file. cfg_chan writes magic_word (index 0) and
// header_length (index 1) and is always ready.
// Throughput is one byte per cycle while the bit queue is not full. A result
// passes from the byte that completes it through the header skip stage into
// the bit queue, then the assembly stage into the output register. When
// out_chan stalls, the queue fills and in_chan drops ready once it is full.
// Reset restores the register defaults and starts a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_bmp_deframer
  import lsbsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lsbsd_in_if.sink   in_chan,
  lsbsd_out_if.source out_chan,
  lsbsd_cfg_if.sink  cfg_chan
);

  logic [MagicW-1:0]  magic_r;
  logic [HdrLenW-1:0] hdr_len_r;

  logic    accept;
  logic    push;
  fwd_t    push_item;
  logic    q_full;
  logic    q_valid;
  fwd_t    q_head;
  logic    pop;
  logic    res_valid;
  result_t res;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MagicReset;
      hdr_len_r <= HeaderReset;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_MAGIC:  magic_r   <= cfg_chan.data[MagicW-1:0];
        CFG_HEADER: hdr_len_r <= cfg_chan.data[HdrLenW-1:0];
        default:    magic_r   <= magic_r;
      endcase
    end
  end

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  lsbsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .file_byte     (in_chan.file_byte),
    .start_of_file (in_chan.start_of_file),
    .header_length (hdr_len_r),
    .push          (push),
    .push_item     (push_item)
  );

  lsbsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  lsbsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .pop        (pop),
    .magic_word (magic_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_chan.ready)
  );

  assign out_chan.valid    = res_valid;
  assign out_chan.out_byte = res.data;
  assign out_chan.kind     = res.kind;
  assign out_chan.last     = res.last;

endmodule

`default_nettype wire

FILE: test/lsbsd_decode_check.sv
// ----------------------------------------------------------------------------
// lsbsd_decode_check
// Watches the byte, result and register channels of the deframer, decodes
// each accepted file byte on its own and compares every result transfer
// field by field with the oldest decoded result still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbsd_decode_check
  import lsbsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lsbsd_in_if  in_mon,
  lsbsd_out_if out_mon,
  lsbsd_cfg_if cfg_mon,
  output int   fail_count,
  output int   outstanding
);

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_MAGIC,
    ST_EXT_LEN,
    ST_EXT_CHARS,
    ST_PAY_LEN,
    ST_PAYLOAD,
    ST_DONE,
    ST_HALTED
  } stage_t;

  logic [MagicW-1:0]  magic_cfg;
  logic [HdrLenW-1:0] hdr_cfg;

  stage_t             stage;
  logic [HdrLenW-1:0] hdr_seen;
  int                 bit_pos;
  logic [LenW-1:0]    gather;
  logic [LenW-1:0]    units_left;
  logic               second_char;

  result_t decoded_q[$];
  result_t head;
  int      mismatches;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  task automatic restart_file();
    stage       = ST_HEADER;
    hdr_seen    = '0;
    units_left  = '0;
    second_char = 1'b0;
    bit_pos     = 0;
    gather      = '0;
  endtask

  task automatic decode_file_byte(input logic [ByteW-1:0] fb, input logic sof);
    logic    hb;
    result_t r;
    hb = fb[0];
    if (sof) restart_file();
    if (stage == ST_HEADER) begin
      if (hdr_seen < hdr_cfg) begin
        hdr_seen = hdr_seen + 1'b1;
        return;
      end
      stage       = ST_MAGIC;
      second_char = 1'b0;
      bit_pos     = 0;
      gather      = '0;
    end
    case (stage)
      ST_MAGIC: begin
        gather[{second_char, bit_pos[2:0]}] = hb;
        bit_pos++;
        if (bit_pos < ByteW) return;
        bit_pos = 0;
        if (!second_char) begin
          second_char = 1'b1;
          return;
        end
        second_char = 1'b0;
        if (gather[MagicW-1:0] != magic_cfg) begin
          stage  = ST_HALTED;
          gather = '0;
          r.data = '0;
          r.kind = KIND_ERR;
          r.last = 1'b0;
          decoded_q.push_back(r);
        end else begin
          stage  = ST_EXT_LEN;
          gather = '0;
        end
      end
      ST_EXT_LEN, ST_PAY_LEN: begin
        gather[bit_pos] = hb;
        bit_pos++;
        if (bit_pos < LenW) return;
        units_left = gather;
        bit_pos    = 0;
        gather     = '0;
        if (stage == ST_EXT_LEN) begin
          stage = (units_left != 0) ? ST_EXT_CHARS : ST_PAY_LEN;
        end else begin
          stage = (units_left != 0) ? ST_PAYLOAD : ST_DONE;
        end
      end
      ST_EXT_CHARS, ST_PAYLOAD: begin
        gather[bit_pos] = hb;
        bit_pos++;
        if (bit_pos < ByteW) return;
        r.data     = gather[ByteW-1:0];
        r.kind     = (stage == ST_PAYLOAD) ? KIND_PAY : KIND_EXT;
        r.last     = 1'b0;
        bit_pos    = 0;
        gather     = '0;
        units_left = units_left - 1'b1;
        if (units_left == 0) begin
          if (stage == ST_PAYLOAD) begin
            r.last = 1'b1;
            stage  = ST_DONE;
          end else begin
            stage = ST_PAY_LEN;
          end
        end
        decoded_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg = MagicReset;
      hdr_cfg   = HeaderReset;
      restart_file();
      decoded_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_MAGIC) begin
          magic_cfg = cfg_mon.data[MagicW-1:0];
        end else if (cfg_mon.index == CFG_HEADER) begin
          hdr_cfg = cfg_mon.data[HdrLenW-1:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_file_byte(in_mon.file_byte, in_mon.start_of_file);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result transfer: data %02h kind %0d last %0b",
                     out_mon.out_byte, out_mon.kind, out_mon.last);
          end
        end else begin
          head = decoded_q.pop_front();
          if (head.data !== out_mon.out_byte || head.kind !== out_mon.kind ||
              head.last !== out_mon.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected data %02h kind %0d last %0b, got data %02h kind %0d last %0b",
                       head.data, head.kind, head.last,
                       out_mon.out_byte, out_mon.kind, out_mon.last);
            end
          end
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= decoded_q.size();
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds the deframer carrier files with hidden bit streams built on the fly:
// good files, magic mismatches, cut-off and oversized streams and plain noise,
// under several register settings and random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lsbsd_pkg::*;

  localparam int IdleLimit     = 2000;
  localparam int HoldCycles    = 200;
  localparam int RandomItems   = 750;

  logic clk = 1'b0;
  logic rst_n;

  lsbsd_in_if  in_chan();
  lsbsd_out_if out_chan();
  lsbsd_cfg_if cfg_chan();

  int fail_count;
  int outstanding;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit quiet         = 1'b0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  logic [MagicW-1:0]  magic_now;
  logic [HdrLenW-1:0] hdr_now;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lsb_stego_bmp_deframer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  lsbsd_decode_check decode_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_mon     (cfg_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic push_file_byte(input logic [ByteW-1:0] fb, input logic sof);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.file_byte     <= fb;
    in_chan.start_of_file <= sof;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  // carrier byte with random upper bits around one hidden bit
  task automatic push_hidden(input bit hb, input logic sof);
    logic [ByteW-1:0] fb;
    fb    = 8'($urandom);
    fb[0] = hb;
    push_file_byte(fb, sof);
  endtask

  // lengths above 40 get only a few units, the next start mark cuts them off
  task automatic send_carrier(input int hdr, input logic [MagicW-1:0] magic,
                              input logic [LenW-1:0] ext_len,
                              input logic [LenW-1:0] pay_len,
                              input bit mark, input int max_bits, input int trail);
    bit               stream[$];
    int               n_ext;
    int               n_pay;
    logic [ByteW-1:0] ch;
    for (int i = 0; i < MagicW; i++) stream.push_back(magic[i]);
    for (int i = 0; i < LenW; i++) stream.push_back(ext_len[i]);
    n_ext = (ext_len > 40) ? 3 : int'(ext_len);
    repeat (n_ext) begin
      ch = 8'($urandom);
      for (int i = 0; i < ByteW; i++) stream.push_back(ch[i]);
    end
    if (ext_len <= 40) begin
      for (int i = 0; i < LenW; i++) stream.push_back(pay_len[i]);
      n_pay = (pay_len > 40) ? 3 : int'(pay_len);
      repeat (n_pay) begin
        ch = 8'($urandom);
        for (int i = 0; i < ByteW; i++) stream.push_back(ch[i]);
      end
    end
    for (int k = 0; k < hdr; k++) push_file_byte(8'($urandom), mark && k == 0);
    foreach (stream[k]) begin
      if (max_bits < 0 || k < max_bits) push_hidden(stream[k], mark && hdr == 0 && k == 0);
    end
    repeat (trail) push_file_byte(8'($urandom), 1'b0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  // drain all results, then give in-flight bytes time to leave the pipeline
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic [MagicW-1:0] magic, input logic [HdrLenW-1:0] hdr);
    settle();
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_HEADER, {8'h00, hdr});
    cfg_chan.valid <= 1'b0;
    magic_now = magic;
    hdr_now   = hdr;
  endtask

  // result side
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // byte side and verdict
  initial begin
    int               pick;
    int               ext_n;
    int               pay_n;
    logic [LenW-1:0]  big;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.file_byte     <= '0;
    in_chan.start_of_file <= 1'b0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.index        <= CFG_MAGIC;
    cfg_chan.data         <= '0;
    magic_now = MagicReset;
    hdr_now   = HeaderReset;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; first file carries no start mark
    send_carrier(54, magic_now, 2, 1, 1'b0, -1, 0);
    // restart inside the header, then a wrong second magic character
    for (int k = 0; k < 6; k++) push_file_byte(8'($urandom), k == 0);
    send_carrier(54, magic_now ^ 16'h0100, 1, 1, 1'b1, 24, 4);

    set_config(16'h0000, 8'd0);
    // empty extension and payload, trailing bytes ignored
    send_carrier(0, 16'h0000, 0, 0, 1'b1, -1, 4);
    // long receiver hold-off while bytes keep coming
    quiet    = 1'b1;
    hold_req = 1'b1;
    send_carrier(0, 16'h0000, 0, 12, 1'b1, -1, 0);
    quiet    = 1'b0;
    send_carrier(0, 16'h0000, 32'hFFFF_FFFF, 0, 1'b1, -1, 0);
    send_carrier(0, 16'h0000, 0, 32'hFFFF_FFFE, 1'b1, -1, 0);

    while (items_sent < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        set_config(16'($urandom), 8'd54);
      end else if (pick == 1) begin
        set_config(($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF, 8'($urandom_range(0, 6)));
      end else begin
        set_config(16'($urandom), 8'($urandom_range(0, 6)));
      end
      repeat ($urandom_range(3, 6)) begin
        if (items_sent >= RandomItems) break;
        quiet = ($urandom_range(0, 3) == 0);
        pick  = $urandom_range(0, 9);
        ext_n = $urandom_range(0, 3);
        pay_n = $urandom_range(0, 6);
        if (pick <= 5) begin
          send_carrier(hdr_now, magic_now, ext_n, pay_n, 1'b1, -1, $urandom_range(0, 3));
        end else if (pick == 6) begin
          send_carrier(hdr_now, magic_now ^ 16'($urandom_range(1, 65535)), ext_n, pay_n,
                       1'b1, -1, $urandom_range(0, 5));
        end else if (pick == 7) begin
          send_carrier(hdr_now, magic_now, ext_n, pay_n, 1'b1, $urandom_range(0, 120), 0);
        end else if (pick == 8) begin
          repeat ($urandom_range(5, 30)) push_file_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          big = {1'b1, 31'($urandom)};
          if ($urandom_range(0, 1) == 0) begin
            send_carrier(hdr_now, magic_now, big, 0, 1'b1, -1, 0);
          end else begin
            send_carrier(hdr_now, magic_now, ext_n, big, 1'b1, -1, 0);
          end
        end
      end
      quiet = 1'b0;
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
